>>> src/gbn_pkg.sv
package gbn_pkg;

   // Sequence number width; the transfer length and window share it
   localparam int SEQ_BITS = 16;
   localparam int ACK_BITS = SEQ_BITS + 1;
   localparam int CNT_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CNT_BITS-1:0] TIMEOUT_RESET = CNT_BITS'(1500);
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE   = 2'd0,
      CSR_TOTAL_COUNT   = 2'd1,
      CSR_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   // Request commands
   typedef enum logic {
      CMD_TICK    = 1'b0,
      CMD_RESTART = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0] window_size;
      logic [SEQ_BITS-1:0] total_count;
      logic [CNT_BITS-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0] base;
      logic [SEQ_BITS-1:0] next;
      logic [SEQ_BITS-1:0] high_water;
      logic [CNT_BITS-1:0] timer_count;
      logic [CNT_BITS-1:0] resend_count;
   } state_type;

   typedef struct packed {
      logic                send_valid;
      logic [SEQ_BITS-1:0] send_seq;
      logic                is_resend;
      logic [CNT_BITS-1:0] resend_total;
      logic [SEQ_BITS-1:0] window_base;
      logic [SEQ_BITS-1:0] next_to_send;
      logic                timed_out;
      logic                done_res;
   } result_type;

endpackage

>>> src/gbn_csr.sv
module gbn_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [gbn_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output gbn_pkg::cfg_type                     cfg
);
   import gbn_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register; other indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_SIZE:   cfg_in.window_size   = csr_wdata[SEQ_BITS-1:0];
            CSR_TOTAL_COUNT:   cfg_in.total_count   = csr_wdata[SEQ_BITS-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[CNT_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size   <= SEQ_BITS'(1);
         cfg_ff.total_count   <= '0;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/gbn_step.sv
module gbn_step (
   input  gbn_pkg::cfg_type                 cfg,
   input  gbn_pkg::state_type               st,
   input  logic                             cmd,
   input  logic                             ack_valid,
   input  logic signed [gbn_pkg::ACK_BITS-1:0] ack_num,
   output gbn_pkg::state_type               st_nxt,
   output gbn_pkg::result_type              res
);
   import gbn_pkg::*;

   logic                active;
   logic [SEQ_BITS:0]   limit;
   logic                send;
   logic                resend;
   logic [SEQ_BITS-1:0] next_sent;
   logic [SEQ_BITS-1:0] hw_sent;
   logic [CNT_BITS-1:0] timer_tick;
   logic [CNT_BITS-1:0] timer_sent;
   logic [CNT_BITS-1:0] timer_ack;
   logic [SEQ_BITS-1:0] ack_seq;
   logic                ack_ok;
   logic [SEQ_BITS-1:0] base_ack;
   logic                tmo;
   logic [SEQ_BITS-1:0] next_fin;
   logic [CNT_BITS-1:0] resend_cnt;

   assign active = st.next < cfg.total_count;

   // Advance the timer, saturating
   assign timer_tick = (st.timer_count == CNT_MAX) ? st.timer_count
                                                   : st.timer_count + CNT_BITS'(1);

   // Send phase: window limit is computed one bit wider so it never wraps
   assign limit     = {1'b0, st.base} + {1'b0, cfg.window_size};
   assign send      = active && ({1'b0, st.next} < limit);
   assign resend    = send && (st.next < st.high_water);
   assign next_sent = send ? st.next + SEQ_BITS'(1) : st.next;
   assign hw_sent   = (send && (next_sent > st.high_water)) ? next_sent : st.high_water;
   assign timer_sent = (send && (st.base == st.next)) ? '0 : timer_tick;
   assign resend_cnt = (resend && (st.resend_count != CNT_MAX))
                       ? st.resend_count + CNT_BITS'(1) : st.resend_count;

   // Acknowledge phase: negative numbers never move the base
   assign ack_seq   = ack_num[SEQ_BITS-1:0];
   assign ack_ok    = ack_valid && !ack_num[ACK_BITS-1]
                      && (ack_seq < cfg.total_count) && (ack_seq > st.base);
   assign base_ack  = ack_ok ? ack_seq : st.base;
   assign timer_ack = (ack_valid && (base_ack == next_sent)) ? '0 : timer_sent;

   // Timeout phase: rewind to the base
   assign tmo      = timer_ack >= cfg.timeout_ticks;
   assign next_fin = tmo ? base_ack : next_sent;

   // Select the new state and build the result
   always_comb begin
      st_nxt = st;
      res    = '0;
      priority if (cmd_type'(cmd) == CMD_RESTART) begin
         st_nxt = '0;
      end else if (active) begin
         st_nxt.base         = base_ack;
         st_nxt.next         = next_fin;
         st_nxt.high_water   = hw_sent;
         st_nxt.timer_count  = timer_ack;
         st_nxt.resend_count = resend_cnt;
         res.send_valid      = send;
         res.send_seq        = send ? st.next : '0;
         res.is_resend       = resend;
         res.timed_out       = tmo;
      end else begin
         st_nxt = st;
      end
      res.resend_total = st_nxt.resend_count;
      res.window_base  = st_nxt.base;
      res.next_to_send = st_nxt.next;
      res.done_res     = st_nxt.next >= cfg.total_count;
   end

endmodule

>>> src/go_back_n_sender.sv
// Go-back-N sender. Each request is one timer tick, optionally carrying an
// acknowledgement number, or a restart command that clears the transfer
// state (configuration is kept). Every request yields exactly one response
// reporting the message sent this tick (if any), whether it was a resend,
// the saturating resend count, the window base and next sequence number
// after the tick, a timeout flag and a done flag. The block accepts one
// request per cycle unless it stalls; each request is held in the request
// register, then in the response register, which drives the response.
// Requests stall only while both registers are full and the response is
// not being taken. Each tick reads and rewrites the sequence and timer
// state as it moves into the response register. Write the configuration
// registers (window size, transfer length, timeout in ticks) only while no
// request is in flight.
module go_back_n_sender (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_cmd,
   input  logic                                      req_ack_valid,
   input  logic signed [gbn_pkg::ACK_BITS-1:0]       req_ack_num,
   // response channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_send_valid,
   output logic [gbn_pkg::SEQ_BITS-1:0]              rsp_send_seq,
   output logic                                      rsp_is_resend,
   output logic [gbn_pkg::CNT_BITS-1:0]              rsp_resend_total,
   output logic [gbn_pkg::SEQ_BITS-1:0]              rsp_window_base,
   output logic [gbn_pkg::SEQ_BITS-1:0]              rsp_next_to_send,
   output logic                                      rsp_timed_out,
   output logic                                      rsp_done_res,
   // configuration
   input  logic                                      csr_wen,
   input  logic [gbn_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import gbn_pkg::*;

   cfg_type                    cfg;
   state_type                  st_ff;
   state_type                  st_in;
   result_type                 res_in;
   result_type                 res_ff;
   logic                       in_valid_ff;
   logic                       cmd_ff;
   logic                       ack_valid_ff;
   logic signed [ACK_BITS-1:0] ack_num_ff;
   logic                       out_valid_ff;
   logic                       advance;

   gbn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbn_step u_step (
      .cfg       (cfg),
      .st        (st_ff),
      .cmd       (cmd_ff),
      .ack_valid (ack_valid_ff),
      .ack_num   (ack_num_ff),
      .st_nxt    (st_in),
      .res       (res_in)
   );

   // Move the held request into the response register when it has room
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Control: pipeline valid bits and the transfer state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         st_ff        <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: request and response registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff       <= req_cmd;
         ack_valid_ff <= req_ack_valid;
         ack_num_ff   <= req_ack_num;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_send_valid   = res_ff.send_valid;
   assign rsp_send_seq     = res_ff.send_seq;
   assign rsp_is_resend    = res_ff.is_resend;
   assign rsp_resend_total = res_ff.resend_total;
   assign rsp_window_base  = res_ff.window_base;
   assign rsp_next_to_send = res_ff.next_to_send;
   assign rsp_timed_out    = res_ff.timed_out;
   assign rsp_done_res     = res_ff.done_res;

   // A resend is always a send
   a_resend_is_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_resend |-> rsp_send_valid)
      else $error("resend flagged without a send");

   // A timeout leaves next equal to the base
   a_timeout_rewinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_next_to_send == rsp_window_base)
      else $error("timeout did not rewind next to base");

   // A restart clears the state
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_type'(cmd_ff) == CMD_RESTART) |=> st_ff == '0)
      else $error("restart left state behind");

   // The resend count never falls on a tick
   a_resend_monotonic: assert property (@(posedge clock) disable iff (reset)
      advance && (cmd_type'(cmd_ff) == CMD_TICK)
      |=> st_ff.resend_count >= $past(st_ff.resend_count))
      else $error("resend count decreased");

   // State only changes when a request moves to the response register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(st_ff))
      else $error("state changed without a transfer");

endmodule
